// File: design/hac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hac_pkg;

    localparam int HAC_TABLE_ENTRIES = 256;
    localparam int HAC_ALIGN_BYTES   = 8;

    localparam int OFF_W  = 17;
    localparam int SIZE_W = 18;

    localparam logic [OFF_W-1:0] HEAP_CAP   = 17'h10000;
    localparam logic [OFF_W-1:0] HEAP_RESET = 17'h10000;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NO_SPACE   = 3'd3,
        ST_HEAP_EMPTY = 3'd4,
        ST_BAD_HANDLE = 3'd5
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] offset;
    } t_entry;

endpackage

`default_nettype wire

// File: design/hac_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hac_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire hac_pkg::t_entry i_entry,
    output hac_pkg::t_entry      o_entry
);
    import hac_pkg::*;

    logic             r_valid;
    logic [OFF_W-1:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_offset <= i_entry.offset;
        end
    end

    assign o_entry.valid  = r_valid;
    assign o_entry.offset = r_offset;

endmodule

`default_nettype wire

// File: design/hac_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module hac_ring #(
    parameter int ENTRIES = hac_pkg::HAC_TABLE_ENTRIES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire hac_pkg::t_entry i_feed,
    output hac_pkg::t_entry      o_head
);
    import hac_pkg::*;

    // cell k passes its entry to cell k-1; the feed enters at the tail
    t_entry cell_q [ENTRIES];
    t_entry cell_d [ENTRIES];

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            if (k == ENTRIES - 1) begin : g_tail
                assign cell_d[k] = i_feed;
            end else begin : g_body
                assign cell_d[k] = cell_q[k+1];
            end

            hac_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_entry (cell_d[k]),
                .o_entry (cell_q[k])
            );
        end
    endgenerate

    assign o_head = cell_q[0];

endmodule

`default_nettype wire

// File: design/hac_align.sv
`timescale 1ns / 1ps
`default_nettype none

module hac_align #(
    parameter int ALIGN_BYTES = hac_pkg::HAC_ALIGN_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic [hac_pkg::OFF_W-1:0]   i_value,
    output logic      [hac_pkg::SIZE_W-1:0]  o_rounded
);
    import hac_pkg::*;

    // ceil(v / A) by reciprocal: exact for any operand below 2^SIZE_W
    localparam int SH = SIZE_W + $clog2(ALIGN_BYTES);
    localparam int PW = SH + SIZE_W;
    localparam longint unsigned RECIP =
        ((longint'(1) << SH) + longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES);

    logic [SIZE_W-1:0] biased;
    logic [PW-1:0]     prod;
    logic [SIZE_W-1:0] r_quot;
    logic [SIZE_W-1:0] r_round;

    assign biased = SIZE_W'(i_value) + SIZE_W'(ALIGN_BYTES - 1);
    assign prod   = PW'(biased) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_quot  <= prod[SH +: SIZE_W];
        r_round <= SIZE_W'(r_quot * SIZE_W'(ALIGN_BYTES));
    end

    assign o_rounded = r_round;

endmodule

`default_nettype wire

// File: design/compacting_handle_allocator_core.sv
// Compacting handle allocator.
// Input words (i_in_valid / o_in_stall) carry a command: allocate
// i_request_bytes, or free handle i_free_handle. Each word yields exactly one
// result word (o_out_valid / i_out_stall) with status, the handle and offset
// given by an allocate, the bump pointer and the live block count.
// The handle table sits in a ring of TABLE_ENTRIES cells that rotates one
// entry per cycle past a single controller while a command walks it:
//   allocate accepted:  size rounding and checks, then a rotation (allocate)
//   free accepted:      rotations to fetch, search and adjust
//   rejected command:   allocate after the size checks, or free on empty heap
//   unallocated handle: free, rejected after the fetch
// One command is in flight at a time; o_in_stall is high from acceptance
// until its result is loaded into the output register. A new command is
// taken while that result still waits on a stalled receiver; the following
// result then holds inside the block until the output register frees up.
// i_cfg_we writes the heap size; do so only while idle.
// Synchronous reset empties the table, clears the bump pointer and count
// and sets the heap size to 65536.
`timescale 1ns / 1ps
`default_nettype none

module compacting_handle_allocator_core #(
    parameter int TABLE_ENTRIES = hac_pkg::HAC_TABLE_ENTRIES,
    parameter int ALIGN_BYTES   = hac_pkg::HAC_ALIGN_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [16:0] i_request_bytes,
    input  wire logic [7:0]  i_free_handle,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_given_handle,
    output logic [15:0]      o_block_offset,
    output logic [16:0]      o_next_free_offset,
    output logic [8:0]       o_live_blocks
);
    import hac_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ROUND,
        S_CHECK,
        S_ALLOC,
        S_FETCH,
        S_SCAN,
        S_GAP,
        S_ADJ,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [OFF_W-1:0]  r_heap_bytes;
    logic [OFF_W-1:0]  r_bump;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_step;
    logic              r_found;
    logic [IDX_W-1:0]  r_hnd;
    logic              r_hv;
    logic [OFF_W-1:0]  r_off;
    logic [OFF_W-1:0]  r_upper;
    logic [OFF_W-1:0]  r_gap;

    t_cmd              r_cmd;
    logic [16:0]       r_req;
    logic [7:0]        r_fh;

    t_status           r_res_status;
    logic [7:0]        r_res_handle;
    logic [15:0]       r_res_offset;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [7:0]        r_out_handle;
    logic [15:0]       r_out_offset;
    logic [16:0]       r_out_next;
    logic [8:0]        r_out_live;

    t_entry            head;
    t_entry            feed;
    logic              shift;
    logic [SIZE_W-1:0] req_round;
    logic [SIZE_W-1:0] heap_round;
    logic [OFF_W-1:0]  limit;
    logic [SIZE_W:0]   need;
    logic              step_last;
    logic              step_hit;
    logic              handle_ok;
    logic              hv_now;
    logic              out_free;

    hac_ring #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (shift),
        .i_feed  (feed),
        .o_head  (head)
    );

    hac_align #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align_req (
        .i_clk     (i_clk),
        .i_value   (r_req),
        .o_rounded (req_round)
    );

    hac_align #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align_heap (
        .i_clk     (i_clk),
        .i_value   (r_heap_bytes),
        .o_rounded (heap_round)
    );

    assign limit     = (heap_round > SIZE_W'(HEAP_CAP)) ? HEAP_CAP : OFF_W'(heap_round);
    assign need      = (SIZE_W + 1)'(r_bump) + (SIZE_W + 1)'(req_round);
    assign step_last = (r_step == LAST_STEP);
    assign step_hit  = (32'(r_step) == 32'(r_fh));
    assign handle_ok = (32'(r_fh) < 32'(TABLE_ENTRIES));
    assign hv_now    = step_hit ? head.valid : r_hv;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        feed  = head;
        shift = 1'b0;
        case (r_state)
            S_ALLOC: begin
                shift = 1'b1;
                if (!r_found && !head.valid) begin
                    feed.valid  = 1'b1;
                    feed.offset = r_bump;
                end
            end
            S_FETCH, S_SCAN: begin
                shift = 1'b1;
            end
            S_ADJ: begin
                shift = 1'b1;
                if (head.valid && head.offset > r_off) begin
                    feed.offset = head.offset - r_gap;
                end
                if (step_hit) begin
                    feed.valid = 1'b0;
                end
            end
            default: begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_bytes <= HEAP_RESET;
            r_bump       <= '0;
            r_count      <= '0;
            r_step       <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_bytes <= i_cfg_data;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_req   <= i_request_bytes;
                        r_fh    <= i_free_handle;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_step       <= '0;
                    r_found      <= 1'b0;
                    r_res_handle <= '0;
                    r_res_offset <= '0;
                    if (r_cmd == CMD_ALLOC) begin
                        r_state <= S_ROUND;
                    end else if (r_count == '0) begin
                        r_res_status <= ST_HEAP_EMPTY;
                        r_state      <= S_EMIT;
                    end else if (!handle_ok) begin
                        r_res_status <= ST_BAD_HANDLE;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_ROUND: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_req == '0) begin
                        r_res_status <= ST_ZERO_SIZE;
                        r_state      <= S_EMIT;
                    end else if (r_count == FULL_CNT) begin
                        r_res_status <= ST_TABLE_FULL;
                        r_state      <= S_EMIT;
                    end else if (need > (SIZE_W + 1)'(limit)) begin
                        r_res_status <= ST_NO_SPACE;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    r_step <= step_last ? '0 : r_step + 1'b1;
                    if (!r_found && !head.valid) begin
                        r_found <= 1'b1;
                        r_hnd   <= r_step;
                    end
                    if (step_last) begin
                        r_bump       <= OFF_W'(need);
                        r_count      <= r_count + 1'b1;
                        r_res_status <= ST_OK;
                        r_res_handle <= 8'(r_found ? r_hnd : r_step);
                        r_res_offset <= 16'(r_bump);
                        r_state      <= S_EMIT;
                    end
                end
                S_FETCH: begin
                    r_step <= step_last ? '0 : r_step + 1'b1;
                    if (step_hit) begin
                        r_off <= head.offset;
                        r_hv  <= head.valid;
                    end
                    if (step_last) begin
                        r_found <= 1'b0;
                        if (!hv_now) begin
                            r_res_status <= ST_BAD_HANDLE;
                            r_state      <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= step_last ? '0 : r_step + 1'b1;
                    if (head.valid && head.offset > r_off &&
                        (!r_found || head.offset < r_upper)) begin
                        r_upper <= head.offset;
                        r_found <= 1'b1;
                    end
                    if (step_last) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_gap   <= r_upper - r_off;
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_step <= step_last ? '0 : r_step + 1'b1;
                    if (step_last) begin
                        if (!r_found) begin
                            r_bump <= r_off;
                        end else if (r_bump >= r_gap) begin
                            r_bump <= r_bump - r_gap;
                        end else begin
                            r_bump <= '0;
                        end
                        r_count      <= r_count - 1'b1;
                        r_res_status <= ST_OK;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_handle <= r_res_handle;
                        r_out_offset <= r_res_offset;
                        r_out_next   <= r_bump;
                        r_out_live   <= 9'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_given_handle     = r_out_handle;
    assign o_block_offset     = r_out_offset;
    assign o_next_free_offset = r_out_next;
    assign o_live_blocks      = r_out_live;

endmodule

`default_nettype wire

// File: design/hac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_given_handle,
    input wire logic [15:0] o_block_offset,
    input wire logic [16:0] o_next_free_offset,
    input wire logic [8:0]  o_live_blocks
);
    import hac_pkg::*;

    // a stalled result word holds its valid, status, bump pointer and count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_next_free_offset) && $stable(o_live_blocks))
        else $error("result word changed under stall");

    // one command in flight: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while one is in flight");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_given_handle == '0 && o_block_offset == '0)
        else $error("rejected command reports a handle or offset");

    a_alloc_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK &&
            (o_given_handle != '0 || o_block_offset != '0) |->
            o_next_free_offset > 17'(o_block_offset))
        else $error("bump pointer not past new block");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_HEAP_EMPTY |-> o_live_blocks == '0)
        else $error("heap empty reported with live blocks");

endmodule

bind compacting_handle_allocator_core hac_checker u_hac_checker (.*);

`default_nettype wire

// File: bench/hac_tb_pkg.sv
`timescale 1ns / 1ps

package hac_tb_pkg;
    import hac_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [7:0]  handle;
        logic [15:0] offset;
        logic [16:0] next_free;
        logic [8:0]  live;
    } t_alloc_result;

    class alloc_scoreboard;
        bit [16:0]     slot_offset [HAC_TABLE_ENTRIES];
        bit            slot_live [HAC_TABLE_ENTRIES];
        bit [16:0]     bump;
        bit [8:0]      live_count;
        bit [16:0]     heap_cfg;
        t_alloc_result expected_q [$];
        int            errors;
        int            checked;
        int            status_seen [6];

        function new();
            foreach (slot_live[i]) begin
                slot_live[i]   = 1'b0;
                slot_offset[i] = '0;
            end
            bump       = '0;
            live_count = '0;
            heap_cfg   = HEAP_RESET;
            errors     = 0;
            checked    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_heap(bit [16:0] v);
            heap_cfg = v;
        endfunction

        function int heap_limit();
            int r;
            r = (int'(heap_cfg) + HAC_ALIGN_BYTES - 1) / HAC_ALIGN_BYTES * HAC_ALIGN_BYTES;
            return (r > int'(HEAP_CAP)) ? int'(HEAP_CAP) : r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // random live handle, -1 when the table is empty
        function int pick_live();
            int live_q [$];
            foreach (slot_live[i]) if (slot_live[i]) live_q.push_back(i);
            if (live_q.size() == 0) return -1;
            return live_q[$urandom_range(0, live_q.size() - 1)];
        endfunction

        function void note_command(t_cmd c, bit [16:0] req, bit [7:0] h);
            t_alloc_result exp_r;
            int            idx;
            int            size;
            bit            found;
            bit [16:0]     base;
            bit [16:0]     upper;
            bit [16:0]     gap;

            exp_r = '0;
            if (c == CMD_ALLOC) begin
                idx = -1;
                for (int i = 0; i < HAC_TABLE_ENTRIES; i++) begin
                    if (idx < 0 && !slot_live[i]) idx = i;
                end
                size = (int'(req) + HAC_ALIGN_BYTES - 1) / HAC_ALIGN_BYTES * HAC_ALIGN_BYTES;
                if (req == 0) begin
                    exp_r.status = ST_ZERO_SIZE;
                end else if (idx < 0) begin
                    exp_r.status = ST_TABLE_FULL;
                end else if (int'(bump) + size > heap_limit()) begin
                    exp_r.status = ST_NO_SPACE;
                end else begin
                    exp_r.status     = ST_OK;
                    exp_r.handle     = idx[7:0];
                    exp_r.offset     = bump[15:0];
                    slot_offset[idx] = bump;
                    slot_live[idx]   = 1'b1;
                    bump             = bump + size[16:0];
                    live_count       = live_count + 1'b1;
                end
            end else begin
                if (live_count == 0) begin
                    exp_r.status = ST_HEAP_EMPTY;
                end else if (!slot_live[h]) begin
                    exp_r.status = ST_BAD_HANDLE;
                end else begin
                    exp_r.status = ST_OK;
                    base  = slot_offset[h];
                    found = 1'b0;
                    upper = '0;
                    foreach (slot_live[i]) begin
                        if (slot_live[i] && slot_offset[i] > base) begin
                            if (!found || slot_offset[i] < upper) upper = slot_offset[i];
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        gap = upper - base;
                        foreach (slot_live[i]) begin
                            if (slot_live[i] && slot_offset[i] > base)
                                slot_offset[i] = slot_offset[i] - gap;
                        end
                        bump = (bump >= gap) ? bump - gap : '0;
                    end else begin
                        bump = base;
                    end
                    slot_live[h] = 1'b0;
                    live_count   = live_count - 1'b1;
                end
            end
            exp_r.next_free = bump;
            exp_r.live      = live_count;
            expected_q.push_back(exp_r);
        endfunction

        task report(string field, int got, int want);
            errors++;
            $display("mismatch on result %0d: %s got %0d, want %0d",
                     checked, field, got, want);
        endtask

        task check_result(t_alloc_result got);
            t_alloc_result want;
            if (expected_q.size() == 0) begin
                report("unexpected word, status", int'(got.status), -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report("status", int'(got.status), int'(want.status));
            if (got.handle !== want.handle)
                report("given_handle", int'(got.handle), int'(want.handle));
            if (got.offset !== want.offset)
                report("block_offset", int'(got.offset), int'(want.offset));
            if (got.next_free !== want.next_free)
                report("next_free_offset", int'(got.next_free), int'(want.next_free));
            if (got.live !== want.live)
                report("live_blocks", int'(got.live), int'(want.live));
            status_seen[int'(want.status)]++;
            checked++;
        endtask
    endclass

endpackage

// File: bench/tb_compacting_handle_allocator_core.sv
`timescale 1ns / 1ps

module tb_compacting_handle_allocator_core;
    import hac_pkg::*;
    import hac_tb_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [16:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        command    = CMD_ALLOC;
    logic [16:0] req_bytes  = '0;
    logic [7:0]  free_hdl   = '0;
    logic        out_stall  = 1'b0;

    wire         in_stall;
    wire         out_valid;
    wire  [2:0]  status;
    wire  [7:0]  given_handle;
    wire  [15:0] block_offset;
    wire  [16:0] next_free_offset;
    wire  [8:0]  live_blocks;

    logic        no_idle    = 1'b0;
    logic        hold_off   = 1'b0;
    int          words_sent = 0;
    int          cycles     = 0;

    alloc_scoreboard sb;

    compacting_handle_allocator_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_command          (command),
        .i_request_bytes    (req_bytes),
        .i_free_handle      (free_hdl),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_given_handle     (given_handle),
        .o_block_offset     (block_offset),
        .o_next_free_offset (next_free_offset),
        .o_live_blocks      (live_blocks)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_word(input t_cmd c, input logic [16:0] req, input logic [7:0] h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        command   <= c;
        req_bytes <= req;
        free_hdl  <= h;
        do @(posedge i_clk); while (in_stall);
        sb.note_command(c, req, h);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap(input logic [16:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_heap(v);
    endtask

    task automatic random_phase(input logic [16:0] heap, input int count,
                                input int alloc_pct, input int size_max, input bit calm);
        int          pick;
        int          sel;
        int          h;
        logic [16:0] req;
        logic [7:0]  fh;
        t_cmd        c;

        write_heap(heap);
        no_idle = calm;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            req  = 17'($urandom_range(0, 17'h1FFFF));
            fh   = 8'($urandom_range(0, 255));
            if (pick < alloc_pct) begin
                c   = CMD_ALLOC;
                sel = $urandom_range(0, 19);
                if (sel == 0)      req = '0;
                else if (sel == 2) req = 17'($urandom_range(1, 65536));
                else if (sel > 2)  req = 17'($urandom_range(1, size_max));
            end else begin
                c = CMD_FREE;
                h = sb.pick_live();
                // a share of frees go to arbitrary handles
                if (pick < 95 && h >= 0) fh = h[7:0];
            end
            send_word(c, req, fh);
        end
        drain();
        no_idle = 1'b0;
    endtask

    // result side: random stall after every word (none in calm phases), plus the long hold-off
    initial begin : result_sink
        int            wait_left;
        t_alloc_result got;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                got.status    = t_status'(status);
                got.handle    = given_handle;
                got.offset    = block_offset;
                got.next_free = next_free_offset;
                got.live      = live_blocks;
                sb.check_result(got);
                wait_left = no_idle ? 0 : $urandom_range(0, 14);
            end
            out_stall <= hold_off || (wait_left > 0);
            if (wait_left > 0) wait_left--;
        end
    end

    initial begin : long_hold
        wait (words_sent >= 420);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        int total_errors;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_heap(17'h10000);
        // directed: empty heap, zero size, rounding, no space, bad handles,
        // free in the middle, at the top and down to empty, whole heap
        send_word(CMD_FREE,  17'd0,      8'd0);
        send_word(CMD_FREE,  17'd0,      8'd255);
        send_word(CMD_ALLOC, 17'd0,      8'd0);
        send_word(CMD_ALLOC, 17'd1,      8'd0);
        send_word(CMD_ALLOC, 17'd7,      8'd0);
        send_word(CMD_ALLOC, 17'd8,      8'd0);
        send_word(CMD_ALLOC, 17'd9,      8'd0);
        send_word(CMD_ALLOC, 17'h1FFFF,  8'd0);
        send_word(CMD_ALLOC, 17'h10000,  8'd0);
        send_word(CMD_FREE,  17'd0,      8'd200);
        send_word(CMD_FREE,  17'd0,      8'd255);
        send_word(CMD_FREE,  17'd0,      8'd1);
        send_word(CMD_ALLOC, 17'd16,     8'd0);
        send_word(CMD_FREE,  17'd0,      8'd1);
        send_word(CMD_FREE,  17'd0,      8'd0);
        send_word(CMD_FREE,  17'd0,      8'd3);
        send_word(CMD_FREE,  17'd0,      8'd2);
        send_word(CMD_ALLOC, 17'h10000,  8'd0);
        send_word(CMD_ALLOC, 17'd1,      8'd0);
        send_word(CMD_ALLOC, 17'd0,      8'd0);
        send_word(CMD_FREE,  17'd0,      8'd0);
        send_word(CMD_ALLOC, 17'hFFFF,   8'd0);
        send_word(CMD_FREE,  17'd0,      8'd0);
        drain();

        random_phase(17'h10000, 360, 90, 32,   1'b0);  // fills the table
        random_phase(17'd1000,  150, 50, 256,  1'b0);  // heap below bump pointer
        random_phase(17'd0,      60, 50, 64,   1'b1);
        random_phase(17'h1FFFF, 200, 55, 8192, 1'b0);
        random_phase(17'd13,     70, 60, 16,   1'b0);
        random_phase(17'd8,      70, 60, 8,    1'b1);
        random_phase(17'h10000, 220, 60, 1024, 1'b0);

        repeat (20) @(posedge i_clk);
        total_errors = sb.errors + sb.pending();
        $display("%0d commands checked over seven random phases in %0d cycles, incl. a %0d-cycle hold",
                 sb.checked, cycles, HOLD_CYCLES);
        $display("statuses: ok %0d, zero %0d, full %0d, no space %0d, empty %0d, bad handle %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
        if (total_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
